// File: sv/tlptm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tlptm_pkg: shared types and constants of the two-level page table manager
// Field widths, command and status codes, entry packing, state machine type.
// ============================================================================
package tlptm_pkg;

    // Field widths
    localparam int VP_W           = 20;
    localparam int FRAME_W        = 20;
    localparam int IDX_W          = 10;
    localparam int ENTRY_W        = 23;
    localparam int CMD_W          = 2;
    localparam int OUT_SLOT_W     = 4;

    // Table geometry
    localparam int DIR_ENTRIES    = 1024;
    localparam int TABLE_ENTRIES  = 1024;
    localparam int MAX_TABLES_DEF = 16;

    // Command codes; the fourth code is a no-op
    localparam logic [CMD_W-1:0] CMD_INIT      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MAP       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_FLAGS = 2'd2;

    // Pool entry packing: frame | user | writable | present
    localparam int E_PRESENT_BIT  = 0;
    localparam int E_WRITABLE_BIT = 1;
    localparam int E_USER_BIT     = 2;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_TABLE    = 2'd1,
        ST_DIR_ABSENT  = 2'd2,
        ST_PAGE_ABSENT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_RST_CLEAR,
        S_INIT_CLEAR,
        S_IDLE,
        S_DIR,
        S_POOL,
        S_HOLD
    } state_t;

    // One result transaction
    typedef struct packed {
        status_t                 status;
        logic [OUT_SLOT_W-1:0]   table_slot;
        logic                    table_allocated;
        logic                    invalidate_page;
    } rsp_t;

    // Clear sequencer control and status
    typedef struct packed {
        logic start;
        logic identity;
    } clr_req_t;

    typedef struct packed {
        logic busy;
        logic last;
    } clr_stat_t;

    // Build a present pool entry
    function automatic logic [ENTRY_W-1:0] make_entry(
        input logic [FRAME_W-1:0] frame,
        input logic               wr,
        input logic               us
    );
        return {frame, us, wr, 1'b1};
    endfunction

endpackage

// File: sv/tlptm_req_if.sv
`timescale 1ns / 1ps
// ============================================================================
// tlptm_req_if: command channel
// Valid/ready channel that carries one page table command per transaction.
// ============================================================================
interface tlptm_req_if;
    import tlptm_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [VP_W-1:0]    virtual_page;
    logic [FRAME_W-1:0] physical_frame;
    logic               writable;
    logic               user_mode;

    modport source (
        output valid, cmd, virtual_page, physical_frame, writable, user_mode,
        input  ready
    );

    modport sink (
        input  valid, cmd, virtual_page, physical_frame, writable, user_mode,
        output ready
    );
endinterface

// File: sv/tlptm_rsp_if.sv
`timescale 1ns / 1ps
// ============================================================================
// tlptm_rsp_if: result channel
// Valid/ready channel that carries one command result per transaction.
// ============================================================================
interface tlptm_rsp_if;
    import tlptm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [OUT_SLOT_W-1:0] table_slot;
    logic                  table_allocated;
    logic                  invalidate_page;

    modport source (
        output valid, status, table_slot, table_allocated, invalidate_page,
        input  ready
    );

    modport sink (
        input  valid, status, table_slot, table_allocated, invalidate_page,
        output ready
    );
endinterface

// File: sv/tlptm_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// tlptm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module tlptm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: sv/tlptm_clear.sv
`timescale 1ns / 1ps
// ============================================================================
// tlptm_clear: clearing sequencer for directory and pool memories
// Sweeps every pool entry once and the directory once per table, either
// to zero or to the identity map of the first 1024 pages through slot 0.
// ============================================================================
module tlptm_clear #(
    parameter int MAX_TABLES = tlptm_pkg::MAX_TABLES_DEF,
    parameter int SLOT_W     = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1,
    parameter int POOL_AW    = $clog2(MAX_TABLES * tlptm_pkg::TABLE_ENTRIES)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlptm_pkg::clr_req_t           req,
    output tlptm_pkg::clr_stat_t          stat,
    output logic                          dir_we,
    output logic [tlptm_pkg::IDX_W-1:0]   dir_addr,
    output logic [SLOT_W:0]               dir_wdata,
    output logic                          pool_we,
    output logic [POOL_AW-1:0]            pool_addr,
    output logic [tlptm_pkg::ENTRY_W-1:0] pool_wdata
);
    import tlptm_pkg::*;

    localparam int POOL_DEPTH = MAX_TABLES * TABLE_ENTRIES;

    logic               busy_reg, busy_next;
    logic               ident_reg, ident_next;
    logic [POOL_AW-1:0] cnt_reg, cnt_next;
    logic               last;
    logic               in_first_table;

    // Sweep state; reset starts a zeroing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            ident_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            ident_reg <= ident_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign last = busy_reg && (cnt_reg == POOL_AW'(POOL_DEPTH - 1));

    // Start, advance, stop at the last entry
    always_comb
    begin
        busy_next  = busy_reg;
        ident_next = ident_reg;
        cnt_next   = cnt_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            ident_next = req.identity;
            cnt_next   = '0;
        end
        else if (busy_reg)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + POOL_AW'(1);
            end
        end
    end

    assign in_first_table = ({1'b0, cnt_reg} < (POOL_AW + 1)'(TABLE_ENTRIES));

    // Directory writes repeat with the same values for every table of the pool
    assign dir_we    = busy_reg;
    assign dir_addr  = cnt_reg[IDX_W-1:0];
    assign dir_wdata = (ident_reg && (cnt_reg[IDX_W-1:0] == '0)) ? {1'b1, SLOT_W'(0)}
                                                                  : '0;

    // Pool: slot 0 holds the identity map after init, all else is zero
    assign pool_we    = busy_reg;
    assign pool_addr  = cnt_reg;
    assign pool_wdata = (ident_reg && in_first_table)
                        ? make_entry(FRAME_W'(cnt_reg[IDX_W-1:0]), 1'b1, 1'b0)
                        : '0;

    assign stat.busy = busy_reg;
    assign stat.last = last;

    // Assertions
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("clear started while a sweep runs");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (last && !req.start) |=> !busy_reg)
        else $error("sweep did not stop after the last entry");

    a_ident_dir0: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && dir_wdata[SLOT_W]) |-> (ident_reg && dir_addr == '0))
        else $error("directory entry marked present outside entry 0 of init");
endmodule

// File: sv/two_level_page_table_manager.sv
`timescale 1ns / 1ps
// ============================================================================
// two_level_page_table_manager: two-level 4 KiB page mapping manager
// Directory RAM and page-table pool RAM with a read-modify-write sequencer.
// ============================================================================
//
//  Channel | Role   | Payload
//  --------+--------+-------------------------------------------------------
//  req     | sink   | cmd, virtual_page, physical_frame, writable, user_mode
//  rsp     | source | status, table_slot, table_allocated, invalidate_page
//
//  Map reads the directory, then writes the pool; set flags reads the
//  directory and the pool, then writes the pool; the unused code only
//  returns a result. Init sweeps the whole pool, MAX_TABLES * 1024 entries
//  (16384 by default). After reset a zeroing sweep runs with req.ready low.
//  One command is in work at a time; a finished result waits in a hold
//  register while rsp stalls, and req is taken again once it moves.
//
module two_level_page_table_manager #(
    parameter int MAX_TABLES = tlptm_pkg::MAX_TABLES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tlptm_req_if.sink   req,
    tlptm_rsp_if.source rsp
);
    import tlptm_pkg::*;

    localparam int SLOT_W     = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int NF_W       = $clog2(MAX_TABLES + 1);
    localparam int POOL_DEPTH = MAX_TABLES * TABLE_ENTRIES;
    localparam int POOL_AW    = $clog2(POOL_DEPTH);
    localparam int DIR_W      = SLOT_W + 1;

    state_t               state_reg, state_next;
    logic [NF_W-1:0]      nf_reg, nf_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_t                 out_reg, out_next;
    rsp_t                 hold_reg, hold_next;

    // Command payload
    logic [CMD_W-1:0]     cmd_reg;
    logic [IDX_W-1:0]     di_reg;
    logic [IDX_W-1:0]     ti_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic                 wr_reg;
    logic                 us_reg;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 accept;

    // Memory ports
    logic                 dir_re;
    logic [DIR_W-1:0]     dir_rdata;
    logic                 fsm_dir_we;
    logic [DIR_W-1:0]     fsm_dir_wdata;
    logic                 dir_we;
    logic [IDX_W-1:0]     dir_waddr;
    logic [DIR_W-1:0]     dir_wdata;
    logic                 pool_re;
    logic [ENTRY_W-1:0]   pool_rdata;
    logic                 fsm_pool_we;
    logic [ENTRY_W-1:0]   fsm_pool_wdata;
    logic                 pool_we;
    logic [POOL_AW-1:0]   pool_waddr;
    logic [ENTRY_W-1:0]   pool_wdata;
    logic [POOL_AW-1:0]   pool_addr;

    // Clear sequencer
    clr_req_t             clr_req;
    clr_stat_t            clr_stat;
    logic                 clr_dir_we;
    logic [IDX_W-1:0]     clr_dir_addr;
    logic [DIR_W-1:0]     clr_dir_wdata;
    logic                 clr_pool_we;
    logic [POOL_AW-1:0]   clr_pool_addr;
    logic [ENTRY_W-1:0]   clr_pool_wdata;

    // Sequencer working values
    logic                 dir_pres;
    logic [SLOT_W-1:0]    dir_slot_q;
    logic [SLOT_W-1:0]    dir_slot_safe;
    logic [SLOT_W-1:0]    slot_sel;
    logic [SLOT_W+3:0]    slot_ext;
    logic                 out_free;
    logic                 done;
    rsp_t                 res;

    tlptm_clear #(
        .MAX_TABLES (MAX_TABLES),
        .SLOT_W     (SLOT_W),
        .POOL_AW    (POOL_AW)
    ) u_clear (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (clr_req),
        .stat       (clr_stat),
        .dir_we     (clr_dir_we),
        .dir_addr   (clr_dir_addr),
        .dir_wdata  (clr_dir_wdata),
        .pool_we    (clr_pool_we),
        .pool_addr  (clr_pool_addr),
        .pool_wdata (clr_pool_wdata)
    );

    tlptm_ram #(
        .WIDTH (DIR_W),
        .DEPTH (DIR_ENTRIES),
        .AW    (IDX_W)
    ) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .re    (dir_re),
        .raddr (req.virtual_page[VP_W-1:IDX_W]),
        .rdata (dir_rdata)
    );

    tlptm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (POOL_DEPTH),
        .AW    (POOL_AW)
    ) u_pool_ram (
        .clk   (clk),
        .we    (pool_we),
        .waddr (pool_waddr),
        .wdata (pool_wdata),
        .re    (pool_re),
        .raddr (pool_addr),
        .rdata (pool_rdata)
    );

    // Sweep owns the write ports while it runs
    assign dir_we     = clr_stat.busy ? clr_dir_we     : fsm_dir_we;
    assign dir_waddr  = clr_stat.busy ? clr_dir_addr   : di_reg;
    assign dir_wdata  = clr_stat.busy ? clr_dir_wdata  : fsm_dir_wdata;
    assign pool_we    = clr_stat.busy ? clr_pool_we    : fsm_pool_we;
    assign pool_waddr = clr_stat.busy ? clr_pool_addr  : pool_addr;
    assign pool_wdata = clr_stat.busy ? clr_pool_wdata : fsm_pool_wdata;

    // Decode the directory entry
    assign dir_pres      = dir_rdata[SLOT_W];
    assign dir_slot_q    = dir_rdata[SLOT_W-1:0];
    assign dir_slot_safe = (int'(dir_slot_q) >= MAX_TABLES) ? '0 : dir_slot_q;

    // Slot in use: fresh allocation, looked-up entry, or latched slot
    always_comb
    begin
        if (state_reg == S_POOL)
        begin
            slot_sel = slot_reg;
        end
        else if (dir_pres)
        begin
            slot_sel = dir_slot_safe;
        end
        else
        begin
            slot_sel = SLOT_W'(nf_reg);
        end
    end

    assign pool_addr = POOL_AW'({slot_sel, ti_reg});
    assign slot_ext  = {4'b0000, slot_sel};
    assign out_free  = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RST_CLEAR;
            nf_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nf_reg        <= nf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= req.cmd;
            di_reg    <= req.virtual_page[VP_W-1:IDX_W];
            ti_reg    <= req.virtual_page[IDX_W-1:0];
            frame_reg <= req.physical_frame;
            wr_reg    <= req.writable;
            us_reg    <= req.user_mode;
        end
        slot_reg <= slot_next;
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    // Sequencer: next state, memory accesses and result
    always_comb
    begin
        state_next     = state_reg;
        nf_next        = nf_reg;
        slot_next      = slot_reg;
        hold_next      = hold_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        req.ready      = 1'b0;
        dir_re         = 1'b0;
        pool_re        = 1'b0;
        fsm_dir_we     = 1'b0;
        fsm_dir_wdata  = {1'b1, slot_sel};
        fsm_pool_we    = 1'b0;
        fsm_pool_wdata = make_entry(frame_reg, wr_reg, us_reg);
        clr_req        = '0;
        done           = 1'b0;
        res            = '0;

        unique case (state_reg)
            S_RST_CLEAR:
            begin
                if (clr_stat.last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_INIT_CLEAR:
            begin
                if (clr_stat.last)
                begin
                    nf_next = NF_W'(1);
                    done    = 1'b1;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    dir_re = 1'b1;
                    priority case (req.cmd)
                        CMD_INIT:
                        begin
                            clr_req.start    = 1'b1;
                            clr_req.identity = 1'b1;
                            state_next       = S_INIT_CLEAR;
                        end
                        CMD_MAP, CMD_SET_FLAGS:
                        begin
                            state_next = S_DIR;
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_DIR:
            begin
                if (cmd_reg == CMD_MAP)
                begin
                    if (!dir_pres && (int'(nf_reg) >= MAX_TABLES))
                    begin
                        res.status = ST_NO_TABLE;
                    end
                    else
                    begin
                        // Allocate a slot when the directory entry is absent
                        if (!dir_pres)
                        begin
                            fsm_dir_we          = 1'b1;
                            nf_next             = nf_reg + NF_W'(1);
                            res.table_allocated = 1'b1;
                        end
                        fsm_pool_we    = 1'b1;
                        res.table_slot = slot_ext[3:0];
                    end
                    done = 1'b1;
                end
                else
                begin
                    if (!dir_pres)
                    begin
                        res.status = ST_DIR_ABSENT;
                        done       = 1'b1;
                    end
                    else
                    begin
                        pool_re    = 1'b1;
                        slot_next  = dir_slot_safe;
                        state_next = S_POOL;
                    end
                end
            end
            S_POOL:
            begin
                if (!pool_rdata[E_PRESENT_BIT])
                begin
                    res.status = ST_PAGE_ABSENT;
                end
                else
                begin
                    // Replace writable and user, keep frame and present
                    fsm_pool_we                    = 1'b1;
                    fsm_pool_wdata                 = pool_rdata;
                    fsm_pool_wdata[E_WRITABLE_BIT] = wr_reg;
                    fsm_pool_wdata[E_USER_BIT]     = us_reg;
                    res.table_slot                 = slot_ext[3:0];
                    res.invalidate_page            = 1'b1;
                end
                done = 1'b1;
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_next       = hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Deliver the result, or park it while the output stalls
        if (done)
        begin
            if (out_free)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                hold_next  = res;
                state_next = S_HOLD;
            end
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.table_slot      = out_reg.table_slot;
    assign rsp.table_allocated = out_reg.table_allocated;
    assign rsp.invalidate_page = out_reg.invalidate_page;

    // Assertions
    a_nf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(nf_reg) <= MAX_TABLES)
        else $error("next free slot beyond table count");

    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clr_stat.busy |-> !req.ready)
        else $error("command taken while memories are being cleared");

    a_no_fsm_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clr_stat.busy |-> !(fsm_dir_we || fsm_pool_we))
        else $error("sequencer write collides with the clearing sweep");

    a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.table_allocated || rsp.invalidate_page))
            |-> (rsp.status == ST_OK && !(rsp.table_allocated && rsp.invalidate_page)))
        else $error("allocate or invalidate flag on a bad result");

    a_alloc_bumps_nf: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_dir_we && !clr_stat.busy) |=> (nf_reg == $past(nf_reg) + NF_W'(1)))
        else $error("slot allocation did not advance the free slot");
endmodule
